### rtl/core/lsrc_pkg.sv
// Shared types, constants and the outcode function for the line segment clipper.
// No dependencies; every other file in rtl/core uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package lsrc_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int QSUM_BITS  = DIFF_BITS + 2;
  localparam int CNT_BITS   = $clog2(PROD_BITS + 1);
  localparam int PASS_LIMIT = 16;
  localparam int PASS_BITS  = $clog2(PASS_LIMIT + 1);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 2'd3;

  localparam logic signed [COORD_BITS-1:0] RST_LEFT   = COORD_BITS'(100);
  localparam logic signed [COORD_BITS-1:0] RST_RIGHT  = COORD_BITS'(300);
  localparam logic signed [COORD_BITS-1:0] RST_BOTTOM = COORD_BITS'(100);
  localparam logic signed [COORD_BITS-1:0] RST_TOP    = COORD_BITS'(300);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
  } win_t;

  typedef struct packed {
    coord_t     x0;
    coord_t     y0;
    coord_t     x1;
    coord_t     y1;
    logic [3:0] c0;
    logic [3:0] c1;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } back_state_t;

  function automatic logic [3:0] outcode(input coord_t x, input coord_t y, input win_t w);
    logic [3:0] c;
    c = 4'd0;
    if ($signed(y) < $signed(w.bottom)) c = c | CODE_BOTTOM;
    if ($signed(y) > $signed(w.top))    c = c | CODE_TOP;
    if ($signed(x) > $signed(w.right))  c = c | CODE_RIGHT;
    if ($signed(x) < $signed(w.left))   c = c | CODE_LEFT;
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/line_segment_rect_clip_core.sv
// Cohen-Sutherland segment clipper: window registers, front queue and clipping back end.
// Depends on lsrc_pkg, lsrc_front, lsrc_back and lsrc_div.
// A trivially accepted or rejected segment goes straight to the result register; otherwise
// each clipping pass runs the multiplier and the serial divider (up to 4 passes on a normal window, 16 at most).
// The back end clips one segment at a time; a two-entry queue takes new transfers meanwhile.
// Reset (rst_n low, synchronous) empties the queue and restores the window to 100..300.
`timescale 1ns / 1ps
`default_nettype none
module line_segment_rect_clip_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [lsrc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [lsrc_pkg::COORD_BITS-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [lsrc_pkg::COORD_BITS-1:0] in_start_x,
  input  wire logic signed [lsrc_pkg::COORD_BITS-1:0] in_start_y,
  input  wire logic signed [lsrc_pkg::COORD_BITS-1:0] in_end_x,
  input  wire logic signed [lsrc_pkg::COORD_BITS-1:0] in_end_y,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_visible,
  output logic signed [lsrc_pkg::COORD_BITS-1:0]    out_clip_start_x,
  output logic signed [lsrc_pkg::COORD_BITS-1:0]    out_clip_start_y,
  output logic signed [lsrc_pkg::COORD_BITS-1:0]    out_clip_end_x,
  output logic signed [lsrc_pkg::COORD_BITS-1:0]    out_clip_end_y
);

  lsrc_pkg::win_t  win_r;
  logic            q_valid, q_pop;
  lsrc_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.left   <= lsrc_pkg::RST_LEFT;
      win_r.right  <= lsrc_pkg::RST_RIGHT;
      win_r.bottom <= lsrc_pkg::RST_BOTTOM;
      win_r.top    <= lsrc_pkg::RST_TOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsrc_pkg::REG_LEFT:   win_r.left   <= cfg_data;
        lsrc_pkg::REG_RIGHT:  win_r.right  <= cfg_data;
        lsrc_pkg::REG_BOTTOM: win_r.bottom <= cfg_data;
        lsrc_pkg::REG_TOP:    win_r.top    <= cfg_data;
        default: ;
      endcase
    end
  end

  lsrc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .win        (win_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  lsrc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .win              (win_r),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_visible      (out_visible),
    .out_clip_start_x (out_clip_start_x),
    .out_clip_start_y (out_clip_start_y),
    .out_clip_end_x   (out_clip_end_x),
    .out_clip_end_y   (out_clip_end_y)
  );

endmodule
`default_nettype wire

### rtl/core/lsrc_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on lsrc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none
module lsrc_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [lsrc_pkg::PROD_BITS-1:0] dividend,
  input  wire logic [lsrc_pkg::DIFF_BITS-1:0] divisor,
  output logic                                done,
  output logic [lsrc_pkg::PROD_BITS-1:0]      quo,
  output logic [lsrc_pkg::DIFF_BITS-1:0]      rem
);

  logic [lsrc_pkg::CNT_BITS-1:0]  cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [lsrc_pkg::PROD_BITS-1:0] dvd_r;
  logic [lsrc_pkg::PROD_BITS-1:0] quo_r;
  logic [lsrc_pkg::DIFF_BITS-1:0] rem_r;
  logic [lsrc_pkg::DIFF_BITS-1:0] dsr_r;
  logic [lsrc_pkg::DIFF_BITS:0]   trial;
  logic                           fits;

  assign trial = {rem_r, dvd_r[lsrc_pkg::PROD_BITS-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= lsrc_pkg::CNT_BITS'(lsrc_pkg::PROD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - lsrc_pkg::CNT_BITS'(1);
        if (cnt_r == lsrc_pkg::CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[lsrc_pkg::PROD_BITS-2:0], 1'b0};
      if (fits) begin
        rem_r <= lsrc_pkg::DIFF_BITS'(trial - {1'b0, dsr_r});
        quo_r <= {quo_r[lsrc_pkg::PROD_BITS-2:0], 1'b1};
      end else begin
        rem_r <= trial[lsrc_pkg::DIFF_BITS-1:0];
        quo_r <= {quo_r[lsrc_pkg::PROD_BITS-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### rtl/core/lsrc_front.sv
// Front end: takes input transfers, computes both outcodes and queues the segment.
// Depends on lsrc_pkg; feeds lsrc_back through a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module lsrc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lsrc_pkg::win_t   win,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lsrc_pkg::coord_t in_start_x,
  input  wire lsrc_pkg::coord_t in_start_y,
  input  wire lsrc_pkg::coord_t in_end_x,
  input  wire lsrc_pkg::coord_t in_end_y,
  output logic                  q_valid,
  output lsrc_pkg::item_t       q_item,
  input  wire logic             q_pop
);

  lsrc_pkg::item_t mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            push;
  lsrc_pkg::item_t new_item;

  assign in_stall = cnt_r == 2'd2;
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    new_item.x0 = in_start_x;
    new_item.y0 = in_start_y;
    new_item.x1 = in_end_x;
    new_item.y1 = in_end_y;
    new_item.c0 = lsrc_pkg::outcode(in_start_x, in_start_y, win);
    new_item.c1 = lsrc_pkg::outcode(in_end_x, in_end_y, win);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (q_pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= new_item;
  end

endmodule
`default_nettype wire

### rtl/core/lsrc_back.sv
// Back end: clipping loop with one multiplier and the serial divider, plus the result register.
// Depends on lsrc_pkg and lsrc_div.
`timescale 1ns / 1ps
`default_nettype none
module lsrc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lsrc_pkg::win_t   win,
  input  wire logic             q_valid,
  input  wire lsrc_pkg::item_t  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_visible,
  output lsrc_pkg::coord_t      out_clip_start_x,
  output lsrc_pkg::coord_t      out_clip_start_y,
  output lsrc_pkg::coord_t      out_clip_end_x,
  output lsrc_pkg::coord_t      out_clip_end_y
);

  localparam int CW = lsrc_pkg::COORD_BITS;
  localparam int DW = lsrc_pkg::DIFF_BITS;
  localparam int QW = lsrc_pkg::QSUM_BITS;

  lsrc_pkg::back_state_t state_r, state_nxt;

  lsrc_pkg::coord_t x0_r, y0_r, x1_r, y1_r;
  logic [3:0]       c0_r, c1_r;
  logic [lsrc_pkg::PASS_BITS-1:0] pass_r;
  logic             vis_r;
  logic [DW-1:0]    mdb_r, mnum_r, uden_r;
  logic             neg_r, den_zero_r, axis_y_r, move0_r;
  lsrc_pkg::coord_t b0_r, edge_r;
  logic [lsrc_pkg::PROD_BITS-1:0] prod_r;

  logic             out_valid_r, out_vis_r;
  lsrc_pkg::coord_t out_x0_r, out_y0_r, out_x1_r, out_y1_r;

  logic             div_start, div_done, out_load;
  logic [lsrc_pkg::PROD_BITS-1:0] div_quo;
  logic [DW-1:0]    div_rem;

  logic             accept_all, reject_any, limit_hit;
  logic [3:0]       cout;
  logic             sel_y;
  lsrc_pkg::coord_t a0, b0, a1, b1, edge_sel;
  logic signed [DW-1:0] den, num, db, num_adj, den_adj;

  logic signed [QW-1:0] qmag, q, base;
  lsrc_pkg::coord_t     newb, nx, ny;

  lsrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (uden_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign accept_all = (c0_r | c1_r) == 4'd0;
  assign reject_any = (c0_r & c1_r) != 4'd0;
  assign limit_hit  = pass_r >= lsrc_pkg::PASS_BITS'(lsrc_pkg::PASS_LIMIT);

  always_comb begin
    cout  = (c0_r != 4'd0) ? c0_r : c1_r;
    sel_y = !((cout & (lsrc_pkg::CODE_LEFT | lsrc_pkg::CODE_RIGHT)) != 4'd0);
    if (!sel_y) begin
      a0 = x0_r; b0 = y0_r; a1 = x1_r; b1 = y1_r;
      edge_sel = ((cout & lsrc_pkg::CODE_LEFT) != 4'd0) ? win.left : win.right;
    end else begin
      a0 = y0_r; b0 = x0_r; a1 = y1_r; b1 = x1_r;
      edge_sel = ((cout & lsrc_pkg::CODE_BOTTOM) != 4'd0) ? win.bottom : win.top;
    end
    den = DW'($signed(a1)) - DW'($signed(a0));
    num = DW'($signed(edge_sel)) - DW'($signed(a0));
    db  = DW'($signed(b1)) - DW'($signed(b0));
    den_adj = den[DW-1] ? -den : den;
    num_adj = den[DW-1] ? -num : num;
  end

  always_comb begin
    qmag = QW'(div_quo[DW-1:0]);
    if (!neg_r) q = qmag;
    else if (div_rem == '0) q = -qmag;
    else q = -qmag - QW'(1);
    base = QW'($signed(b0_r)) + q;
    if (div_rem != '0 && base < 0) base = base + QW'(1);
    newb = den_zero_r ? b0_r : base[CW-1:0];
    if (axis_y_r) begin
      ny = edge_r; nx = newb;
    end else begin
      nx = edge_r; ny = newb;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsrc_pkg::ST_IDLE:   if (q_valid) state_nxt = lsrc_pkg::ST_CHECK;
      lsrc_pkg::ST_CHECK:  begin
        if (accept_all || reject_any || limit_hit) state_nxt = lsrc_pkg::ST_OUT;
        else state_nxt = lsrc_pkg::ST_MUL;
      end
      lsrc_pkg::ST_MUL:    state_nxt = lsrc_pkg::ST_DSTART;
      lsrc_pkg::ST_DSTART: state_nxt = lsrc_pkg::ST_DIV;
      lsrc_pkg::ST_DIV:    if (div_done) state_nxt = lsrc_pkg::ST_FIX;
      lsrc_pkg::ST_FIX:    state_nxt = lsrc_pkg::ST_CHECK;
      lsrc_pkg::ST_OUT:    if (!out_valid_r || !out_stall) state_nxt = lsrc_pkg::ST_IDLE;
      default:             state_nxt = lsrc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      lsrc_pkg::ST_IDLE:   q_pop = q_valid;
      lsrc_pkg::ST_DSTART: div_start = 1'b1;
      lsrc_pkg::ST_OUT:    out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsrc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x0_r   <= q_item.x0;
      y0_r   <= q_item.y0;
      x1_r   <= q_item.x1;
      y1_r   <= q_item.y1;
      c0_r   <= q_item.c0;
      c1_r   <= q_item.c1;
      pass_r <= '0;
    end
    if (state_r == lsrc_pkg::ST_CHECK) begin
      vis_r      <= accept_all;
      mdb_r      <= db[DW-1] ? DW'(-db) : DW'(db);
      mnum_r     <= num_adj[DW-1] ? DW'(-num_adj) : DW'(num_adj);
      uden_r     <= DW'(den_adj);
      neg_r      <= num_adj[DW-1] != db[DW-1];
      den_zero_r <= den == '0;
      b0_r       <= b0;
      edge_r     <= edge_sel;
      axis_y_r   <= sel_y;
      move0_r    <= c0_r != 4'd0;
    end
    if (state_r == lsrc_pkg::ST_MUL) begin
      prod_r <= lsrc_pkg::PROD_BITS'(mdb_r) * lsrc_pkg::PROD_BITS'(mnum_r);
    end
    if (state_r == lsrc_pkg::ST_FIX) begin
      pass_r <= pass_r + lsrc_pkg::PASS_BITS'(1);
      if (move0_r) begin
        x0_r <= nx;
        y0_r <= ny;
        c0_r <= lsrc_pkg::outcode(nx, ny, win);
      end else begin
        x1_r <= nx;
        y1_r <= ny;
        c1_r <= lsrc_pkg::outcode(nx, ny, win);
      end
    end
    if (out_load) begin
      out_vis_r <= vis_r;
      out_x0_r  <= x0_r;
      out_y0_r  <= y0_r;
      out_x1_r  <= x1_r;
      out_y1_r  <= y1_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visible      = out_vis_r;
  assign out_clip_start_x = out_x0_r;
  assign out_clip_start_y = out_y0_r;
  assign out_clip_end_x   = out_x1_r;
  assign out_clip_end_y   = out_y1_r;

endmodule
`default_nettype wire
